// ===== design/isg_pkg.sv =====
// Shared types, constants and helper functions of the idle state governor.
// Used by isg_addsub and idle_state_governor_core; depends on nothing.
package isg_pkg;

  // Default number of histogram bins.
  localparam int ISG_MAX_STATES = 4;
  // Number of states that have residency and exit latency registers.
  localparam int NREGS = 4;
  // Width of the state loop counter (holds the state count itself).
  localparam int CNT_W = 3;
  localparam int BIN_W = 16;
  localparam logic [BIN_W:0] PULSE   = 17'd1024;
  localparam logic [BIN_W:0] BIN_MAX = 17'd65535;
  localparam int DECAY_SHIFT = 3;
  localparam logic [31:0] MIN_PROMO_RES = 32'd200000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_NUM_STATES = 3'd0;
  localparam logic [2:0] REG_RES_LAST   = 3'd3;

  // Stretch phase: no stretch, resident in a state, promoted stretch goes on.
  localparam logic [1:0] PHASE_NONE     = 2'd0;
  localparam logic [1:0] PHASE_RESIDENT = 2'd1;
  localparam logic [1:0] PHASE_CONT     = 2'd2;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_LEN, S_ELAP, S_REM, S_DEEP, S_SUM, S_SPLIT, S_BACK, S_PROMO,
    S_ARM, S_PDL, S_DUE, S_EARLY, S_DUR, S_MEAS, S_MEAS2, S_SCAN, S_HSUM,
    S_HCMP, S_BUMP, S_FIN
  } isg_state_t;

  // One operation for the shared 64-bit adder/subtractor.
  typedef struct packed {
    logic        sub;
    logic [63:0] a;
    logic [63:0] b;
  } isg_op_t;

  // Decay by one eighth; small values drop to zero.
  function automatic logic [BIN_W-1:0] shrink(input logic [BIN_W-1:0] m);
    logic [BIN_W-1:0] d;
    d = m >> DECAY_SHIFT;
    return (d != '0) ? m - d : '0;
  endfunction

  // Add one pulse, saturating.
  function automatic logic [BIN_W-1:0] bump(input logic [BIN_W-1:0] m);
    logic [BIN_W:0] v;
    v = {1'b0, m} + PULSE;
    return (v > BIN_MAX) ? BIN_MAX[BIN_W-1:0] : v[BIN_W-1:0];
  endfunction

  // 32-bit r <= 64-bit v.
  function automatic logic le64(input logic [31:0] r, input logic [63:0] v);
    return (v[63:32] != '0) || (r <= v[31:0]);
  endfunction

  // 2*r <= v, r 32-bit, v 64-bit.
  function automatic logic dbl_le64(input logic [31:0] r, input logic [63:0] v);
    return (v[63:33] != '0) || ({r, 1'b0} <= v[32:0]);
  endfunction

endpackage

// ===== design/isg_addsub.sv =====
// Shared 64-bit adder/subtractor of the idle state governor sequencer.
// Depends on isg_pkg for the operation struct.
module isg_addsub
  import isg_pkg::*;
(
  input  isg_op_t     op,
  output logic [63:0] res,
  output logic        co    // carry out on add, borrow on subtract
);

  logic [64:0] sum;

  // a + b, or a + ~b + 1 for a - b
  assign sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {64'd0, op.sub};
  assign res = sum[63:0];
  assign co  = op.sub ? ~sum[64] : sum[64];

endmodule

// ===== design/idle_state_governor_core.sv =====
// Idle state governor: per-entry idle state choice with decaying histograms.
// Depends on isg_pkg and isg_addsub.
//
// Usage:
//   Input words arrive on in_* (tuser = func: 0 idle entry, 1 wakeup).
//   Every input word yields exactly one result word on out_*.
//   The user writes configuration through cfg_we/cfg_addr/cfg_wdata only while idle (not enforced).
// Sequencing:
//   One word is worked on at a time; in_tready is high only when the
//   sequencer is idle. All 64-bit arithmetic runs through one shared
//   adder/subtractor and the bins are visited one per cycle. The next word
//   is taken in the cycle after the result is registered.
// Reset:
//   rst_n (synchronous) clears the bins, the stretch state and the
//   configuration (one state in use, all residencies and latencies zero).
// Back-pressure:
//   The result sits in an output register; the next word is accepted while
//   it waits, and that word's result is held back until the register frees.
module idle_state_governor_core
  import isg_pkg::*;
#(
  parameter int MAX_STATES = ISG_MAX_STATES
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // now[63:0], deadline_valid[64],
                                  // deadline[128:65], scheduling_away[129], 0
  input  logic         in_tuser,  // func
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // selected_state[1:0], promotion_armed[2],
                                  // promotion_deadline[66:3],
                                  // promotion_cancelled[67], stretch_closed[68], 0
  // configuration
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  localparam int CAP   = (MAX_STATES < NREGS) ? MAX_STATES : NREGS;
  localparam int IDX_W = $clog2(MAX_STATES);

  // configuration registers
  logic [2:0]  num_states_r;
  logic [31:0] residency_r [NREGS];
  logic [31:0] exit_lat_r [NREGS];

  // histogram bins
  logic [BIN_W-1:0] hit_r [MAX_STATES];
  logic [BIN_W-1:0] icp_r [MAX_STATES];
  logic [BIN_W-1:0] hit_nxt [MAX_STATES];
  logic [BIN_W-1:0] icp_nxt [MAX_STATES];

  // sequencer
  isg_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // captured input word
  logic [63:0] now_r, dl_r;
  logic        dv_r, away_r;

  // stretch state
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  entered_r, entered_nxt;
  logic [63:0] start_r, start_nxt;
  logic [63:0] len_r, len_nxt;
  logic        pending_r, pending_nxt;
  logic [63:0] offset_r, offset_nxt;

  // working registers
  logic [63:0] elapsed_r, elapsed_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic        elok_r, elok_nxt;
  logic [63:0] meas_r, meas_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic        carry_r, carry_nxt;
  logic [CNT_W-1:0] ts_r, ts_nxt;
  logic [CNT_W-1:0] sel_r, sel_nxt;
  logic [19:0] total_r, total_nxt;
  logic [17:0] hsum_r, hsum_nxt;
  logic [17:0] isum_r, isum_nxt;
  logic [17:0] part_r, part_nxt;
  logic [BIN_W-1:0] imax_r, imax_nxt;
  logic [CNT_W-1:0] imax_at_r, imax_at_nxt;
  logic [CNT_W-1:0] tbin_r, tbin_nxt;
  logic [CNT_W-1:0] dbin_r, dbin_nxt;

  // pending result
  logic        r_armed_r, r_armed_nxt;
  logic [63:0] r_pdl_r, r_pdl_nxt;
  logic        r_canc_r, r_canc_nxt;
  logic        r_closed_r, r_closed_nxt;

  // output register
  logic        out_valid_r;
  logic [71:0] out_data_r;

  // shared unit
  isg_op_t     op;
  logic [63:0] au_res;
  logic        au_co;

  isg_addsub u_addsub (
    .op  (op),
    .res (au_res),
    .co  (au_co)
  );

  // derived values
  logic [CNT_W-1:0] n_act;
  logic [31:0]      res_cur;
  logic [63:0]      el64;
  logic [BIN_W-1:0] hit_cur, icp_cur;
  logic             in_acc, slot_free, loop_end;
  logic [17:0]      part_add;
  logic [20:0]      split_lhs, split_rhs;

  assign n_act = (num_states_r == '0) ? CNT_W'(1) :
                 (num_states_r > CNT_W'(CAP)) ? CNT_W'(CAP) : num_states_r;
  assign res_cur = ((cnt_r != '0) && (cnt_r < CNT_W'(NREGS))) ?
                   residency_r[cnt_r[1:0]] : 32'd0;
  assign el64     = {32'd0, exit_lat_r[entered_r]};
  assign hit_cur  = hit_r[cnt_r[IDX_W-1:0]];
  assign icp_cur  = icp_r[cnt_r[IDX_W-1:0]];
  assign in_acc   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign loop_end = (cnt_r >= n_act);
  assign part_add = part_r + {2'd0, icp_cur};
  assign split_lhs = {2'd0, isum_r, 1'b0};
  assign split_rhs = {1'b0, total_r - {2'd0, hsum_r}};

  // handshake outputs
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // shared unit operand select
  always_comb begin
    op = '{sub: 1'b1, a: now_r, b: start_r};
    unique case (state_r)
      S_LEN:   op = '{sub: 1'b1, a: dl_r, b: (phase_r == PHASE_CONT) ? start_r : now_r};
      S_ELAP:  op = '{sub: 1'b1, a: now_r, b: start_r};
      S_REM:   op = '{sub: 1'b1, a: len_r, b: elapsed_r};
      S_PDL:   op = '{sub: 1'b0, a: start_r, b: offset_r};
      S_DUE:   op = '{sub: 1'b0, a: start_r, b: offset_r};
      S_EARLY: op = '{sub: 1'b1, a: now_r, b: tmp_r};
      S_DUR:   op = '{sub: 1'b1, a: now_r, b: start_r};
      S_MEAS:  op = '{sub: 1'b1, a: elapsed_r, b: el64};
      S_MEAS2: op = '{sub: 1'b1, a: elapsed_r, b: el64 >> 1};
      S_HSUM:  op = '{sub: 1'b0, a: meas_r, b: el64 >> 1};
      S_HCMP:  op = '{sub: 1'b1, a: tmp_r, b: len_r};
      default: op = '{sub: 1'b1, a: now_r, b: start_r};
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_tuser) state_nxt = S_LEN;
          else if (phase_r == PHASE_RESIDENT || phase_r == PHASE_CONT) state_nxt = S_DUE;
          else state_nxt = S_FIN;
        end
      end
      S_LEN:   state_nxt = S_ELAP;
      S_ELAP:  state_nxt = S_REM;
      S_REM:   state_nxt = (phase_r == PHASE_CONT) ? S_PROMO : S_DEEP;
      S_DEEP:  if (loop_end || !le64(res_cur, len_r)) state_nxt = S_SUM;
      S_SUM:   if (loop_end) state_nxt = S_SPLIT;
      S_SPLIT: state_nxt = (split_lhs <= split_rhs) ? S_ARM : S_BACK;
      S_BACK: begin
        if (({part_add, 1'b0} > {1'b0, isum_r} && cnt_r <= imax_at_r) || cnt_r == '0)
          state_nxt = S_ARM;
      end
      S_PROMO: if (loop_end) state_nxt = S_ARM;
      S_ARM: begin
        if (loop_end || (res_cur >= MIN_PROMO_RES && !le64(res_cur, elapsed_r) &&
                         dbl_le64(res_cur, len_r)))
          state_nxt = S_PDL;
      end
      S_PDL:   state_nxt = S_FIN;
      S_DUE:   state_nxt = S_EARLY;
      S_EARLY: state_nxt = (away_r || !pending_r || carry_r || au_co) ? S_DUR : S_FIN;
      S_DUR:   state_nxt = S_MEAS;
      S_MEAS:  state_nxt = au_co ? S_SCAN : S_MEAS2;
      S_MEAS2: state_nxt = S_SCAN;
      S_SCAN:  if (loop_end) state_nxt = S_HSUM;
      S_HSUM:  state_nxt = S_HCMP;
      S_HCMP:  state_nxt = S_BUMP;
      S_BUMP:  state_nxt = S_FIN;
      S_FIN:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt = cnt_r;
    phase_nxt = phase_r;
    entered_nxt = entered_r;
    start_nxt = start_r;
    len_nxt = len_r;
    pending_nxt = pending_r;
    offset_nxt = offset_r;
    elapsed_nxt = elapsed_r;
    rem_nxt = rem_r;
    elok_nxt = elok_r;
    meas_nxt = meas_r;
    tmp_nxt = tmp_r;
    carry_nxt = carry_r;
    ts_nxt = ts_r;
    sel_nxt = sel_r;
    total_nxt = total_r;
    hsum_nxt = hsum_r;
    isum_nxt = isum_r;
    part_nxt = part_r;
    imax_nxt = imax_r;
    imax_at_nxt = imax_at_r;
    tbin_nxt = tbin_r;
    dbin_nxt = dbin_r;
    r_armed_nxt = r_armed_r;
    r_pdl_nxt = r_pdl_r;
    r_canc_nxt = r_canc_r;
    r_closed_nxt = r_closed_r;
    for (int i = 0; i < MAX_STATES; i++) begin
      hit_nxt[i] = hit_r[i];
      icp_nxt[i] = icp_r[i];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sel_nxt = '0;
          r_armed_nxt = 1'b0;
          r_pdl_nxt = '0;
          r_canc_nxt = 1'b0;
          r_closed_nxt = 1'b0;
        end
      end
      // sleep length from the stretch start (new stretch starts now)
      S_LEN: begin
        if (phase_r != PHASE_CONT) start_nxt = now_r;
        if (!dv_r) len_nxt = '1;
        else len_nxt = (!au_co && au_res != '0) ? au_res : '0;
      end
      S_ELAP: elapsed_nxt = au_res;
      S_REM: begin
        rem_nxt = au_res;
        elok_nxt = !au_co;
        cnt_nxt = CNT_W'(1);
        ts_nxt = '0;
        sel_nxt = '0;
      end
      // deepest state whose residency fits the sleep length
      S_DEEP: begin
        if (loop_end || !le64(res_cur, len_r)) begin
          cnt_nxt = '0;
          total_nxt = '0;
          hsum_nxt = '0;
          isum_nxt = '0;
          imax_nxt = '0;
          imax_at_nxt = '0;
        end else begin
          ts_nxt = cnt_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // bin totals
      S_SUM: begin
        if (!loop_end) begin
          total_nxt = total_r + {4'd0, hit_cur} + {4'd0, icp_cur};
          if (cnt_r < ts_r) begin
            hsum_nxt = hsum_r + {2'd0, hit_cur};
            isum_nxt = isum_r + {2'd0, icp_cur};
            if (icp_cur >= imax_r) begin
              imax_nxt = icp_cur;
              imax_at_nxt = cnt_r;
            end
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SPLIT: begin
        if (split_lhs <= split_rhs) begin
          sel_nxt = ts_r;
          cnt_nxt = ts_r + 1'b1;
          pending_nxt = 1'b0;
          offset_nxt = '0;
        end else begin
          cnt_nxt = ts_r - 1'b1;
          part_nxt = '0;
        end
      end
      // walk down accumulating intercepts
      S_BACK: begin
        part_nxt = part_add;
        sel_nxt = cnt_r;
        if (({part_add, 1'b0} > {1'b0, isum_r} && cnt_r <= imax_at_r) || cnt_r == '0) begin
          cnt_nxt = cnt_r + 1'b1;
          pending_nxt = 1'b0;
          offset_nxt = '0;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      // promoted stretch: deepest state past break-even that still fits
      S_PROMO: begin
        if (loop_end) begin
          cnt_nxt = sel_r + 1'b1;
          pending_nxt = 1'b0;
          offset_nxt = '0;
        end else begin
          if (le64(res_cur, elapsed_r) && elok_r && le64(res_cur, rem_r))
            sel_nxt = cnt_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // first deeper state worth a promotion deadline
      S_ARM: begin
        if (!loop_end) begin
          if (res_cur >= MIN_PROMO_RES && !le64(res_cur, elapsed_r) &&
              dbl_le64(res_cur, len_r)) begin
            pending_nxt = 1'b1;
            offset_nxt = {32'd0, res_cur};
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_PDL: begin
        phase_nxt = PHASE_RESIDENT;
        entered_nxt = sel_r[1:0];
        r_armed_nxt = pending_r;
        r_pdl_nxt = pending_r ? au_res : '0;
      end
      // wakeup: was the promotion due yet
      S_DUE: begin
        tmp_nxt = au_res;
        carry_nxt = au_co;
      end
      S_EARLY: begin
        r_canc_nxt = pending_r;
        pending_nxt = 1'b0;
        offset_nxt = '0;
        if (away_r || !pending_r || carry_r || au_co) begin
          phase_nxt = PHASE_NONE;
          r_closed_nxt = 1'b1;
        end else begin
          phase_nxt = PHASE_CONT;
        end
      end
      S_DUR: elapsed_nxt = au_res;
      S_MEAS: begin
        if (au_co) meas_nxt = elapsed_r >> 1;
        cnt_nxt = '0;
        tbin_nxt = '0;
        dbin_nxt = '0;
      end
      S_MEAS2: meas_nxt = au_res;
      // decay every bin in use and find the timer and duration bins
      S_SCAN: begin
        if (!loop_end) begin
          hit_nxt[cnt_r[IDX_W-1:0]] = shrink(hit_cur);
          icp_nxt[cnt_r[IDX_W-1:0]] = shrink(icp_cur);
          if (le64(res_cur, len_r)) begin
            tbin_nxt = cnt_r;
            if (le64(res_cur, meas_r)) dbin_nxt = cnt_r;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_HSUM: begin
        tmp_nxt = au_res;
        carry_nxt = au_co;
      end
      S_HCMP: begin
        carry_nxt = (dbin_r == tbin_r) && (carry_r || !au_co);
        cnt_nxt = ((dbin_r == tbin_r) && (carry_r || !au_co)) ? tbin_r : dbin_r;
      end
      S_BUMP: begin
        if (carry_r) hit_nxt[cnt_r[IDX_W-1:0]] = bump(hit_cur);
        else icp_nxt[cnt_r[IDX_W-1:0]] = bump(icp_cur);
      end
      default: ;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      phase_r <= PHASE_NONE;
      entered_r <= '0;
      start_r <= '0;
      len_r <= '0;
      pending_r <= 1'b0;
      offset_r <= '0;
      out_valid_r <= 1'b0;
      num_states_r <= 3'd1;
      for (int i = 0; i < NREGS; i++) begin
        residency_r[i] <= '0;
        exit_lat_r[i] <= '0;
      end
      for (int i = 0; i < MAX_STATES; i++) begin
        hit_r[i] <= '0;
        icp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      phase_r <= phase_nxt;
      entered_r <= entered_nxt;
      start_r <= start_nxt;
      len_r <= len_nxt;
      pending_r <= pending_nxt;
      offset_r <= offset_nxt;
      for (int i = 0; i < MAX_STATES; i++) begin
        hit_r[i] <= hit_nxt[i];
        icp_r[i] <= icp_nxt[i];
      end
      // output word register
      if (state_r == S_FIN && slot_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      // configuration writes
      if (cfg_we) begin
        if (cfg_addr == REG_NUM_STATES) num_states_r <= cfg_wdata[2:0];
        else if (cfg_addr <= REG_RES_LAST) residency_r[cfg_addr[1:0]] <= cfg_wdata;
        else exit_lat_r[cfg_addr[1:0]] <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r  <= in_tdata[63:0];
      dv_r   <= in_tdata[64];
      dl_r   <= in_tdata[128:65];
      away_r <= in_tdata[129];
    end
    elapsed_r <= elapsed_nxt;
    rem_r <= rem_nxt;
    elok_r <= elok_nxt;
    meas_r <= meas_nxt;
    tmp_r <= tmp_nxt;
    carry_r <= carry_nxt;
    ts_r <= ts_nxt;
    sel_r <= sel_nxt;
    total_r <= total_nxt;
    hsum_r <= hsum_nxt;
    isum_r <= isum_nxt;
    part_r <= part_nxt;
    imax_r <= imax_nxt;
    imax_at_r <= imax_at_nxt;
    tbin_r <= tbin_nxt;
    dbin_r <= dbin_nxt;
    r_armed_r <= r_armed_nxt;
    r_pdl_r <= r_pdl_nxt;
    r_canc_r <= r_canc_nxt;
    r_closed_r <= r_closed_nxt;
    if (state_r == S_FIN && slot_free)
      out_data_r <= {3'd0, r_closed_r, r_canc_r, r_pdl_r, r_armed_r, sel_r[1:0]};
  end

endmodule
